FILE: design/sxfr_pkg.sv
// shared types and constants for the sync-byte frame receiver
`timescale 1ns / 1ps
package sxfr_pkg;

  // frame format
  localparam logic [7:0] SYNC_BYTE     = 8'hAA;
  localparam logic [3:0] LAST_POS      = 4'd11;
  localparam logic [7:0] PAGE_SETTINGS = 8'd16;
  localparam logic [7:0] PAGE_CONTROL  = 8'd6;
  localparam logic [2:0] LEVEL_MASK    = 3'h7;

  // result tdata layout, lowest bit first
  localparam int TDATA_W = 40;
  localparam int CIRC_LO = 0;
  localparam int REGEN_LO = 16;
  localparam int ASSIST_LO = 19;
  localparam int REQ_BIT = 22;
  localparam int SETPT_LO = 23;

  typedef enum logic [1:0] {
    KIND_SETTINGS = 2'd0,
    KIND_CONTROL  = 2'd1,
    KIND_OTHER    = 2'd2
  } page_kind_t;

  // one checked frame, classified, as it waits in the queue
  typedef struct packed {
    page_kind_t  kind;
    logic [7:0]  b4;
    logic [7:0]  b5;
    logic [7:0]  b6;
    logic [7:0]  b7;
    logic [7:0]  b8;
  } frame_desc_t;

endpackage

FILE: design/sxfr_front.sv
// front end: sync hunt, byte collection, xor check and page classification
`timescale 1ns / 1ps
module sxfr_front
  import sxfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        q_full,
  output logic        q_push,
  output frame_desc_t q_desc
);

  typedef enum logic [1:0] {
    ST_HUNT    = 2'b01,
    ST_PAYLOAD = 2'b10
  } rx_state_t;

  rx_state_t  state;
  logic [3:0] pos;
  logic [7:0] run_xor;
  logic [7:0] xor_next;
  logic [7:0] page, b4, b5, b6, b7, b8;
  logic       beat;

  assign s_tready = !q_full;
  assign beat     = s_tvalid && s_tready;
  assign xor_next = run_xor ^ s_tdata;

  // control: hunt for sync, count payload bytes, keep the running xor
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_HUNT;
      pos     <= 4'd0;
      run_xor <= 8'd0;
      q_push  <= 1'b0;
    end else begin
      q_push <= 1'b0;
      case (state)
        ST_HUNT: begin
          if (beat && s_tdata == SYNC_BYTE) begin
            state   <= ST_PAYLOAD;
            pos     <= 4'd1;
            run_xor <= SYNC_BYTE;
          end
        end
        ST_PAYLOAD: begin
          if (beat) begin
            run_xor <= xor_next;
            pos     <= pos + 4'd1;
            if (pos == LAST_POS) begin
              state  <= ST_HUNT;
              q_push <= (xor_next == 8'd0);
            end
          end
        end
        default: state <= ST_HUNT;
      endcase
    end
  end

  // capture the frame bytes that get decoded
  always_ff @(posedge clk) begin
    if (beat && state == ST_PAYLOAD) begin
      case (pos)
        4'd3:    page <= s_tdata;
        4'd4:    b4   <= s_tdata;
        4'd5:    b5   <= s_tdata;
        4'd6:    b6   <= s_tdata;
        4'd7:    b7   <= s_tdata;
        4'd8:    b8   <= s_tdata;
        default: ;
      endcase
    end
  end

  // classify the page
  always_comb begin
    q_desc.b4 = b4;
    q_desc.b5 = b5;
    q_desc.b6 = b6;
    q_desc.b7 = b7;
    q_desc.b8 = b8;
    if (page == PAGE_SETTINGS)     q_desc.kind = KIND_SETTINGS;
    else if (page == PAGE_CONTROL) q_desc.kind = KIND_CONTROL;
    else                           q_desc.kind = KIND_OTHER;
  end

endmodule

FILE: design/sxfr_fifo.sv
// short queue of checked frames between front and back end
`timescale 1ns / 1ps
module sxfr_fifo
  import sxfr_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  frame_desc_t push_desc,
  input  logic        pop,
  output frame_desc_t pop_desc,
  output logic        empty,
  output logic        full
);

  localparam int PTR_W   = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);

  frame_desc_t        slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [COUNT_W-1:0] count;
  logic               do_push, do_pop;

  assign empty   = (count == '0);
  assign full    = (count == COUNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_desc = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_desc;
  end

endmodule

FILE: design/sxfr_back.sv
// back end: applies a checked frame to the held values and drives the result
`timescale 1ns / 1ps
module sxfr_back
  import sxfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_data,
  input  logic               q_empty,
  input  frame_desc_t        q_desc,
  output logic               q_pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,
  output logic [1:0]         m_tuser
);

  logic        throttle_from_adc;
  logic [15:0] circ, circ_next;
  logic [2:0]  regen, regen_next;
  logic [2:0]  assist, assist_next;
  logic [15:0] setpt, setpt_next;
  logic        req_next;

  // config register
  always_ff @(posedge clk) begin
    if (rst) throttle_from_adc <= 1'b0;
    else if (cfg_valid) throttle_from_adc <= cfg_data;
  end

  assign q_pop = !q_empty && (!m_tvalid || m_tready);

  // page decode onto the held values
  always_comb begin
    circ_next   = circ;
    regen_next  = regen;
    assist_next = assist;
    setpt_next  = setpt;
    req_next    = 1'b0;
    case (q_desc.kind)
      KIND_SETTINGS: begin
        circ_next   = {q_desc.b5, q_desc.b4};
        regen_next  = q_desc.b6[2:0] & LEVEL_MASK;
        assist_next = q_desc.b6[5:3] & LEVEL_MASK;
      end
      KIND_CONTROL: begin
        req_next = (q_desc.b4 != 8'd0);
        if (!throttle_from_adc) setpt_next = {q_desc.b8, q_desc.b7};
      end
      default: setpt_next = 16'd0;
    endcase
  end

  // held values
  always_ff @(posedge clk) begin
    if (rst) begin
      circ   <= 16'd0;
      regen  <= 3'd0;
      assist <= 3'd0;
      setpt  <= 16'd0;
    end else if (q_pop) begin
      circ   <= circ_next;
      regen  <= regen_next;
      assist <= assist_next;
      setpt  <= setpt_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_tuser <= q_desc.kind;
      m_tdata <= {1'b0, setpt_next, req_next, assist_next, regen_next, circ_next};
    end
  end

endmodule

FILE: design/sync_xor_frame_receiver_decoder.sv
// top level of the sync-byte frame receiver with xor check and page decode
`timescale 1ns / 1ps
// Takes one received byte per beat and can accept a byte every cycle while the
// frame queue is not full. A frame starts at a 0xAA sync byte and spans 12
// bytes; when the xor of all 12 is zero it yields one result beat carrying the
// page kind and the held settings and setpoint. Checked frames wait in a queue
// of FIFO_DEPTH entries; s_tready falls only while that queue is full, which
// happens only when the result side stalls for whole frames. The user writes
// throttle_from_adc over the cfg channel only while idle; the block does not check.
module sync_xor_frame_receiver_decoder
  import sxfr_pkg::*;
#(
  parameter int FIFO_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  // cfg_data: throttle_from_adc
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  // s_tdata: rx_byte[7:0]
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,
  // m_tdata: wheel_size[15:0], regen_setting[18:16], assist_setting[21:19],
  //          autodetect_request[22], current_setpoint[38:23], zero pad[39]
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,
  // m_tuser: page_kind[1:0]
  output logic [1:0]         m_tuser
);

  frame_desc_t push_desc, pop_desc;
  logic        push, pop, empty, full;

  assign cfg_ready = 1'b1;

  // byte intake and frame check
  sxfr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (full),
    .q_push   (push),
    .q_desc   (push_desc)
  );

  // frame queue
  sxfr_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .pop_desc  (pop_desc),
    .empty     (empty),
    .full      (full)
  );

  // decode and result
  sxfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_empty   (empty),
    .q_desc    (pop_desc),
    .q_pop     (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

FILE: design/sxfr_checker.sv
// port-level checks for the frame receiver, bound to the top level
`timescale 1ns / 1ps
module sxfr_checker
  import sxfr_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata,
  input logic [1:0]         m_tuser
);

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // page kind is one of the three kinds
  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser == KIND_SETTINGS || m_tuser == KIND_CONTROL ||
                 m_tuser == KIND_OTHER)
    else $error("bad page kind");

  // other page clears the setpoint and never requests autodetect
  a_other_page: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_OTHER |->
      m_tdata[SETPT_LO +: 16] == 16'd0 && !m_tdata[REQ_BIT])
    else $error("other page result not cleared");

  // autodetect only on control pages
  a_req_control: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[REQ_BIT] |-> m_tuser == KIND_CONTROL)
    else $error("autodetect on non-control page");

endmodule

bind sync_xor_frame_receiver_decoder sxfr_checker u_sxfr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
